// File: rtl/fssk_pkg.sv
package fssk_pkg;

	localparam int unsigned IDLE_BITS = 20;
	localparam int unsigned HB_BITS = 16;
	localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;
	localparam logic [HB_BITS-1:0] HB_RESET = 16'd30;
	// test request threshold is idle * 5 > interval * 6
	localparam int unsigned CMP_BITS = IDLE_BITS + 3;
	localparam logic [CMP_BITS-1:0] IDLE_MUL = 23'd5;
	localparam logic [CMP_BITS-1:0] HB_MUL = 23'd6;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_MSG   = 2'd1,
		FUNC_START = 2'd2,
		FUNC_RSVD  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		MSG_LOGON     = 3'd0,
		MSG_HEARTBEAT = 3'd1,
		MSG_TEST_REQ  = 3'd2,
		MSG_REJECT    = 3'd3,
		MSG_RESEND    = 3'd4,
		MSG_LOGOUT    = 3'd5,
		MSG_SEQ_RESET = 3'd6,
		MSG_OTHER     = 3'd7
	} mtype_t;

	typedef enum logic [1:0] {
		GF_ABSENT = 2'd0,
		GF_YES    = 2'd1,
		GF_NO     = 2'd2,
		GF_OTHER  = 2'd3
	} gap_fill_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_RESEND    = 3'd1,
		ACT_LOGON     = 3'd2,
		ACT_LOGOUT    = 3'd3,
		ACT_HEARTBEAT = 3'd4,
		ACT_HB_ECHO   = 3'd5,
		ACT_TEST_REQ  = 3'd6,
		ACT_REJECT    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		RSN_NONE     = 2'd0,
		RSN_LOWER    = 2'd1,
		RSN_REASON_5 = 2'd2
	} reason_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_IGNORED  = 2'd1,
		ST_GAP      = 2'd2,
		ST_ENDED    = 2'd3
	} status_t;

	typedef struct packed {
		func_t       func;
		mtype_t      mtype;
		logic [31:0] msg_seq;
		logic [31:0] new_seq;
		logic        poss_dup;
		gap_fill_t   gap_fill;
		logic        frame_bad;
		logic        interval_present;
		logic [15:0] interval_value;
		logic [63:0] test_id;
	} in_item_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] range_begin;
		logic [31:0] range_end;
		reason_t     reject_reason;
		logic [63:0] echo_id;
		status_t     status;
		logic        running;
		logic        logged_on;
		logic [31:0] expected_seq;
	} out_item_t;

endpackage

// File: rtl/fix_session_sequence_keeper_top.sv
// path: input register, then the combinational engine, then the result register
// throughput: one item per cycle while out_stall is low; the input register, the state
// update and the result register each take one item a cycle
// reset (arst_n low, asynchronous): no item held, session stopped, not logged on,
// expected sequence number 1, idle count 0, heartbeat interval 30 ticks
module fix_session_sequence_keeper_top #(
	parameter int unsigned SEQ_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fssk_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output fssk_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic                valid_s1;
	fssk_pkg::in_item_t  item_s1;
	logic                advance;
	logic                fire;
	fssk_pkg::out_item_t result;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && advance;

	fssk_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fssk_engine #(
		.SEQ_BITS (SEQ_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result)
	);

	fssk_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// File: rtl/fssk_in_stage.sv
module fssk_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fssk_pkg::in_item_t  in_item,
	input  logic                advance,
	output logic                valid_s1,
	output fssk_pkg::in_item_t  item_s1
);

	logic vld_q;

	// the held item leaves when the engine takes it
	assign in_stall = vld_q && !advance;
	assign valid_s1 = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!in_stall) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/fssk_engine.sv
module fssk_engine #(
	parameter int unsigned SEQ_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  fssk_pkg::in_item_t  item,
	input  logic                cfg_wr,
	input  logic [15:0]         cfg_data,
	output fssk_pkg::out_item_t result
);

	logic [SEQ_BITS-1:0] expected_q, expected_d;
	logic                logon_q, logon_d;
	logic                on_q, on_d;
	logic [fssk_pkg::IDLE_BITS-1:0] idle_q, idle_d, idle_inc;
	logic [fssk_pkg::HB_BITS-1:0]   hb_q, hb_d;
	logic [SEQ_BITS-1:0] seq_w, nseq_w, exp_inc;
	logic [fssk_pkg::CMP_BITS-1:0] idle_x5, hb_x6;
	fssk_pkg::action_t   action;
	fssk_pkg::reason_t   reason;
	fssk_pkg::status_t   status;
	logic [63:0]         echo;
	logic                rng_en;

	assign seq_w    = SEQ_BITS'(item.msg_seq);
	assign nseq_w   = SEQ_BITS'(item.new_seq);
	assign exp_inc  = expected_q + SEQ_BITS'(1);
	assign idle_inc = (idle_q == fssk_pkg::IDLE_MAX) ? idle_q
		: idle_q + fssk_pkg::IDLE_BITS'(1);
	assign idle_x5  = fssk_pkg::CMP_BITS'(idle_inc) * fssk_pkg::IDLE_MUL;
	assign hb_x6    = fssk_pkg::CMP_BITS'(hb_q) * fssk_pkg::HB_MUL;

	always_comb begin
		expected_d = expected_q;
		logon_d    = logon_q;
		on_d       = on_q;
		idle_d     = idle_q;
		hb_d       = hb_q;
		action     = fssk_pkg::ACT_NONE;
		reason     = fssk_pkg::RSN_NONE;
		status     = fssk_pkg::ST_ACCEPTED;
		echo       = '0;
		rng_en     = 1'b0;
		if (item.func == fssk_pkg::FUNC_START) begin
			on_d = 1'b1;
		end else if (item.func == fssk_pkg::FUNC_RSVD || !on_q) begin
			status = fssk_pkg::ST_IGNORED;
		end else if (item.func == fssk_pkg::FUNC_TICK) begin
			idle_d = idle_inc;
			if (idle_x5 > hb_x6) begin
				action = fssk_pkg::ACT_TEST_REQ;
			end else if (fssk_pkg::CMP_BITS'(idle_inc) > fssk_pkg::CMP_BITS'(hb_q)) begin
				action = fssk_pkg::ACT_HEARTBEAT;
			end
		end else begin
			idle_d = '0;
			if (!logon_q) begin
				if (item.mtype != fssk_pkg::MSG_LOGON) begin
					action = fssk_pkg::ACT_LOGOUT;
					status = fssk_pkg::ST_ENDED;
					on_d   = 1'b0;
				end else if (seq_w > expected_q) begin
					action = fssk_pkg::ACT_RESEND;
					rng_en = 1'b1;
					status = fssk_pkg::ST_GAP;
				end else begin
					logon_d    = 1'b1;
					expected_d = seq_w + SEQ_BITS'(1);
					action     = fssk_pkg::ACT_LOGON;
				end
			end else if (item.frame_bad) begin
				status = fssk_pkg::ST_IGNORED;
			end else if (seq_w > expected_q) begin
				action = fssk_pkg::ACT_RESEND;
				rng_en = 1'b1;
				status = fssk_pkg::ST_GAP;
			end else if (seq_w < expected_q && item.mtype != fssk_pkg::MSG_SEQ_RESET) begin
				if (item.poss_dup) begin
					status = fssk_pkg::ST_IGNORED;
				end else begin
					action = fssk_pkg::ACT_LOGOUT;
					status = fssk_pkg::ST_ENDED;
					on_d   = 1'b0;
				end
			end else begin
				unique case (item.mtype)
					fssk_pkg::MSG_TEST_REQ: begin
						action     = fssk_pkg::ACT_HB_ECHO;
						echo       = item.test_id;
						expected_d = exp_inc;
					end
					fssk_pkg::MSG_HEARTBEAT: begin
						if (item.interval_present) begin
							hb_d = item.interval_value;
						end
						expected_d = exp_inc;
					end
					fssk_pkg::MSG_REJECT: begin
						expected_d = exp_inc;
					end
					fssk_pkg::MSG_RESEND: begin
						action     = fssk_pkg::ACT_RESEND;
						rng_en     = 1'b1;
						expected_d = exp_inc;
					end
					fssk_pkg::MSG_LOGOUT: begin
						on_d   = 1'b0;
						status = fssk_pkg::ST_ENDED;
					end
					fssk_pkg::MSG_SEQ_RESET: begin
						if (item.gap_fill == fssk_pkg::GF_YES) begin
							if (seq_w < expected_q) begin
								if (item.poss_dup) begin
									status = fssk_pkg::ST_IGNORED;
								end else begin
									action = fssk_pkg::ACT_LOGOUT;
									status = fssk_pkg::ST_ENDED;
									on_d   = 1'b0;
								end
							end else if (nseq_w > seq_w) begin
								expected_d = nseq_w;
							end else begin
								action = fssk_pkg::ACT_REJECT;
								reason = fssk_pkg::RSN_LOWER;
								status = fssk_pkg::ST_IGNORED;
							end
						end else if (item.gap_fill == fssk_pkg::GF_NO) begin
							if (nseq_w >= expected_q) begin
								expected_d = nseq_w;
							end else begin
								action = fssk_pkg::ACT_REJECT;
								reason = fssk_pkg::RSN_REASON_5;
								status = fssk_pkg::ST_IGNORED;
							end
						end else begin
							status = fssk_pkg::ST_IGNORED;
						end
					end
					default: begin
						// repeated logon and unknown types
						status = fssk_pkg::ST_IGNORED;
					end
				endcase
			end
		end
	end

	always_comb begin
		result.action        = action;
		// reject carries the expected number as its reference
		result.range_begin   = (rng_en || action == fssk_pkg::ACT_REJECT)
			? 32'(expected_q) : 32'd0;
		result.range_end     = rng_en ? 32'(expected_q) : 32'd0;
		result.reject_reason = reason;
		result.echo_id       = echo;
		result.status        = status;
		result.running       = on_d;
		result.logged_on     = logon_d;
		result.expected_seq  = 32'(expected_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= SEQ_BITS'(1);
			logon_q    <= 1'b0;
			on_q       <= 1'b0;
			idle_q     <= '0;
			hb_q       <= fssk_pkg::HB_RESET;
		end else begin
			if (fire) begin
				expected_q <= expected_d;
				logon_q    <= logon_d;
				on_q       <= on_d;
				idle_q     <= idle_d;
			end
			if (cfg_wr) begin
				hb_q <= cfg_data;
			end else if (fire) begin
				hb_q <= hb_d;
			end
		end
	end

endmodule

// File: rtl/fssk_out_stage.sv
module fssk_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fssk_pkg::out_item_t result,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_stall,
	output fssk_pkg::out_item_t out_item
);

	logic                vld_s2;
	fssk_pkg::out_item_t item_s2;

	// a new result may enter when the register is empty or being drained
	assign advance   = !vld_s2 || !out_stall;
	assign out_valid = vld_s2;
	assign out_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			item_s2 <= result;
		end
	end

endmodule

// File: rtl/fssk_checker.sv
module fssk_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input fssk_pkg::out_item_t out_item
);

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	ap_ended_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == fssk_pkg::ST_ENDED |-> !out_item.running)
		else $error("session ended but still running");

	ap_logon_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.action == fssk_pkg::ACT_LOGON
		|-> out_item.logged_on && out_item.status == fssk_pkg::ST_ACCEPTED)
		else $error("logon reply without logon state");

	ap_resend_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.action == fssk_pkg::ACT_RESEND
		|-> out_item.range_begin == out_item.range_end)
		else $error("resend range mismatch");

	ap_gap_no_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == fssk_pkg::ST_GAP
		|-> out_item.action == fssk_pkg::ACT_RESEND
		&& out_item.expected_seq == out_item.range_begin)
		else $error("gap did not request resend from expected number");

endmodule

bind fix_session_sequence_keeper_top fssk_checker u_fssk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// File: tb/sv/fix_session_sequence_keeper_top_tb.sv
`timescale 1ns / 100ps

module fix_session_sequence_keeper_top_tb;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned ITEMS_PER_PHASE = 310;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam logic [19:0] IDLE_TOP = 20'hFFFFF;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	fssk_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	fssk_pkg::out_item_t out_item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [15:0]         cfg_data;

	fix_session_sequence_keeper_top #(.SEQ_BITS(32)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// session state as the keeper should hold it
	logic [31:0] exp_seq;
	logic        logon_ok;
	logic        sess_on;
	logic [19:0] idle_cnt;
	logic [15:0] hb_ticks;

	fssk_pkg::out_item_t pending_replies[$];
	int unsigned errors;
	int unsigned tick_left;

	// directed stimulus table
	fssk_pkg::in_item_t  row_item[$];
	int unsigned         row_reps[$];
	bit                  row_typed[$];
	fssk_pkg::out_item_t row_reply[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic fssk_pkg::out_item_t step_keeper(input fssk_pkg::in_item_t it);
		fssk_pkg::out_item_t r;
		int unsigned five_idle;
		int unsigned six_hb;
		r = '0;
		r.action = fssk_pkg::ACT_NONE;
		r.reject_reason = fssk_pkg::RSN_NONE;
		r.status = fssk_pkg::ST_ACCEPTED;
		if (it.func == fssk_pkg::FUNC_START) begin
			sess_on = 1'b1;
		end else if (it.func == fssk_pkg::FUNC_RSVD || !sess_on) begin
			r.status = fssk_pkg::ST_IGNORED;
		end else if (it.func == fssk_pkg::FUNC_TICK) begin
			if (idle_cnt != IDLE_TOP)
				idle_cnt = idle_cnt + 1'b1;
			five_idle = int'(idle_cnt) * 5;
			six_hb = int'(hb_ticks) * 6;
			if (five_idle > six_hb)
				r.action = fssk_pkg::ACT_TEST_REQ;
			else if (idle_cnt > hb_ticks)
				r.action = fssk_pkg::ACT_HEARTBEAT;
		end else begin
			idle_cnt = '0;
			if (!logon_ok) begin
				if (it.mtype != fssk_pkg::MSG_LOGON) begin
					r.action = fssk_pkg::ACT_LOGOUT;
					r.status = fssk_pkg::ST_ENDED;
					sess_on = 1'b0;
				end else if (it.msg_seq > exp_seq) begin
					r.action = fssk_pkg::ACT_RESEND;
					r.range_begin = exp_seq;
					r.range_end = exp_seq;
					r.status = fssk_pkg::ST_GAP;
				end else begin
					logon_ok = 1'b1;
					exp_seq = it.msg_seq + 1'b1;
					r.action = fssk_pkg::ACT_LOGON;
				end
			end else if (it.frame_bad) begin
				r.status = fssk_pkg::ST_IGNORED;
			end else if (it.msg_seq > exp_seq) begin
				r.action = fssk_pkg::ACT_RESEND;
				r.range_begin = exp_seq;
				r.range_end = exp_seq;
				r.status = fssk_pkg::ST_GAP;
			end else if (it.msg_seq < exp_seq && it.mtype != fssk_pkg::MSG_SEQ_RESET) begin
				if (it.poss_dup) begin
					r.status = fssk_pkg::ST_IGNORED;
				end else begin
					r.action = fssk_pkg::ACT_LOGOUT;
					r.status = fssk_pkg::ST_ENDED;
					sess_on = 1'b0;
				end
			end else begin
				case (it.mtype)
					fssk_pkg::MSG_TEST_REQ: begin
						r.action = fssk_pkg::ACT_HB_ECHO;
						r.echo_id = it.test_id;
						exp_seq = exp_seq + 1'b1;
					end
					fssk_pkg::MSG_HEARTBEAT: begin
						if (it.interval_present)
							hb_ticks = it.interval_value;
						exp_seq = exp_seq + 1'b1;
					end
					fssk_pkg::MSG_REJECT: begin
						exp_seq = exp_seq + 1'b1;
					end
					fssk_pkg::MSG_RESEND: begin
						r.action = fssk_pkg::ACT_RESEND;
						r.range_begin = exp_seq;
						r.range_end = exp_seq;
						exp_seq = exp_seq + 1'b1;
					end
					fssk_pkg::MSG_LOGOUT: begin
						sess_on = 1'b0;
						r.status = fssk_pkg::ST_ENDED;
					end
					fssk_pkg::MSG_SEQ_RESET: begin
						if (it.gap_fill == fssk_pkg::GF_YES) begin
							if (it.msg_seq < exp_seq) begin
								if (it.poss_dup) begin
									r.status = fssk_pkg::ST_IGNORED;
								end else begin
									r.action = fssk_pkg::ACT_LOGOUT;
									r.status = fssk_pkg::ST_ENDED;
									sess_on = 1'b0;
								end
							end else if (it.new_seq > it.msg_seq) begin
								exp_seq = it.new_seq;
							end else begin
								r.action = fssk_pkg::ACT_REJECT;
								r.range_begin = exp_seq;
								r.reject_reason = fssk_pkg::RSN_LOWER;
								r.status = fssk_pkg::ST_IGNORED;
							end
						end else if (it.gap_fill == fssk_pkg::GF_NO) begin
							if (it.new_seq >= exp_seq) begin
								exp_seq = it.new_seq;
							end else begin
								r.action = fssk_pkg::ACT_REJECT;
								r.range_begin = exp_seq;
								r.reject_reason = fssk_pkg::RSN_REASON_5;
								r.status = fssk_pkg::ST_IGNORED;
							end
						end else begin
							r.status = fssk_pkg::ST_IGNORED;
						end
					end
					default: begin
						r.status = fssk_pkg::ST_IGNORED;
					end
				endcase
			end
		end
		r.running = sess_on;
		r.logged_on = logon_ok;
		r.expected_seq = exp_seq;
		return r;
	endfunction

	function automatic fssk_pkg::in_item_t mk_in(input fssk_pkg::func_t f,
			input fssk_pkg::mtype_t m,
			input logic [31:0] s, input logic [31:0] ns, input logic dup,
			input fssk_pkg::gap_fill_t g, input logic bad, input logic ip,
			input logic [15:0] iv, input logic [63:0] tid);
		fssk_pkg::in_item_t it;
		it.func = f;
		it.mtype = m;
		it.msg_seq = s;
		it.new_seq = ns;
		it.poss_dup = dup;
		it.gap_fill = g;
		it.frame_bad = bad;
		it.interval_present = ip;
		it.interval_value = iv;
		it.test_id = tid;
		return it;
	endfunction

	function automatic fssk_pkg::out_item_t mk_out(input fssk_pkg::action_t a,
			input logic [31:0] rb,
			input logic [31:0] re, input fssk_pkg::status_t st, input logic run,
			input logic lg, input logic [31:0] ex);
		fssk_pkg::out_item_t r;
		r = '0;
		r.action = a;
		r.range_begin = rb;
		r.range_end = re;
		r.reject_reason = fssk_pkg::RSN_NONE;
		r.status = st;
		r.running = run;
		r.logged_on = lg;
		r.expected_seq = ex;
		return r;
	endfunction

	task automatic add_row(input fssk_pkg::in_item_t it, input int unsigned reps,
			input bit typed, input fssk_pkg::out_item_t want);
		row_item.push_back(it);
		row_reps.push_back(reps);
		row_typed.push_back(typed);
		row_reply.push_back(want);
	endtask

	// random item shaped by the current session state
	function automatic fssk_pkg::in_item_t gen_item();
		fssk_pkg::in_item_t it;
		int unsigned p;
		int unsigned q;
		it.func = fssk_pkg::FUNC_MSG;
		it.mtype = fssk_pkg::mtype_t'($urandom_range(0, 7));
		it.msg_seq = exp_seq;
		it.new_seq = $urandom;
		it.poss_dup = $urandom_range(0, 1);
		it.gap_fill = fssk_pkg::gap_fill_t'($urandom_range(0, 3));
		it.frame_bad = ($urandom_range(0, 15) == 0);
		it.interval_present = $urandom_range(0, 1);
		it.interval_value = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'($urandom_range(1, 40));
		it.test_id = {$urandom, $urandom};
		p = $urandom_range(0, 99);
		if (tick_left > 0) begin
			tick_left--;
			it.func = fssk_pkg::FUNC_TICK;
		end else if (p < 3) begin
			it.func = fssk_pkg::FUNC_RSVD;
		end else if (!sess_on) begin
			if (p < 85)
				it.func = fssk_pkg::FUNC_START;
			else if (p < 92)
				it.func = fssk_pkg::FUNC_TICK;
		end else if (p < 22) begin
			it.func = fssk_pkg::FUNC_TICK;
			tick_left = $urandom_range(0, 40);
		end else if (p < 25) begin
			it.func = fssk_pkg::FUNC_START;
		end else if (!logon_ok) begin
			if ($urandom_range(0, 3) != 0) begin
				it.mtype = fssk_pkg::MSG_LOGON;
				it.msg_seq = exp_seq - $urandom_range(0, 2);
				if ($urandom_range(0, 9) == 0)
					it.msg_seq = exp_seq + $urandom_range(1, 3);
			end
		end else begin
			q = $urandom_range(0, 99);
			if (q < 15)
				it.mtype = fssk_pkg::MSG_HEARTBEAT;
			else if (q < 30)
				it.mtype = fssk_pkg::MSG_TEST_REQ;
			else if (q < 40)
				it.mtype = fssk_pkg::MSG_REJECT;
			else if (q < 52)
				it.mtype = fssk_pkg::MSG_RESEND;
			else if (q < 55)
				it.mtype = fssk_pkg::MSG_LOGOUT;
			else if (q < 75)
				it.mtype = fssk_pkg::MSG_SEQ_RESET;
			else if (q < 82)
				it.mtype = fssk_pkg::MSG_LOGON;
			else
				it.mtype = fssk_pkg::MSG_OTHER;
			q = $urandom_range(0, 99);
			if (q < 80)
				it.msg_seq = exp_seq;
			else if (q < 88)
				it.msg_seq = exp_seq + $urandom_range(1, 4);
			else if (q < 96)
				it.msg_seq = exp_seq - $urandom_range(1, 4);
			else
				it.msg_seq = $urandom;
			if (it.mtype == fssk_pkg::MSG_SEQ_RESET && $urandom_range(0, 9) < 7)
				it.new_seq = exp_seq + $urandom_range(0, 8) - 2;
		end
		return it;
	endfunction

	task automatic send_item(input fssk_pkg::in_item_t it, input bit typed,
			input fssk_pkg::out_item_t want);
		fssk_pkg::out_item_t guess;
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		guess = step_keeper(it);
		pending_replies.push_back(typed ? want : guess);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_interval(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		hb_ticks = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cmp_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, fname, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_replies
		fssk_pkg::out_item_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: result with none expected, expected none actual %h",
					$time, out_item);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				cmp_field("action", want.action, out_item.action);
				cmp_field("range_begin", want.range_begin, out_item.range_begin);
				cmp_field("range_end", want.range_end, out_item.range_end);
				cmp_field("reject_reason", want.reject_reason, out_item.reject_reason);
				cmp_field("echo_id", want.echo_id, out_item.echo_id);
				cmp_field("status", want.status, out_item.status);
				cmp_field("running", want.running, out_item.running);
				cmp_field("logged_on", want.logged_on, out_item.logged_on);
				cmp_field("expected_seq", want.expected_seq, out_item.expected_seq);
			end
		end
	end

	// receiver: changing stall density, plus long hold-offs to back up the block
	initial begin
		int unsigned cyc;
		int unsigned pct;
		out_stall = 1'b0;
		cyc = 0;
		pct = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: pct = 0;
					1: pct = 30;
					default: pct = 70;
				endcase
			end
			if (cyc == 700 || cyc == 2200) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				cyc += HOLD_CYCLES;
			end else begin
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
					(out_valid === 1'b1 && !out_stall) || (cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		fssk_pkg::in_item_t  it;
		fssk_pkg::out_item_t none;
		logic [15:0] phase_hb[4];
		int unsigned done;
		int unsigned burst;
		int unsigned gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		tick_left = 0;
		exp_seq = 32'd1;
		logon_ok = 1'b0;
		sess_on = 1'b0;
		idle_cnt = '0;
		hb_ticks = 16'd30;
		none = '0;

		// not running yet: everything ignored
		add_row(mk_in(fssk_pkg::FUNC_TICK, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 1,
			mk_out(fssk_pkg::ACT_NONE, 0, 0, fssk_pkg::ST_IGNORED, 0, 0, 32'd1));
		add_row(mk_in(fssk_pkg::FUNC_RSVD, fssk_pkg::MSG_OTHER, '1, '1, 1,
			fssk_pkg::GF_OTHER, 1, 1, '1, '1), 1, 1,
			mk_out(fssk_pkg::ACT_NONE, 0, 0, fssk_pkg::ST_IGNORED, 0, 0, 32'd1));
		add_row(mk_in(fssk_pkg::FUNC_START, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 1,
			mk_out(fssk_pkg::ACT_NONE, 0, 0, fssk_pkg::ST_ACCEPTED, 1, 0, 32'd1));
		// non-logon first ends the session
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, 1, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 1,
			mk_out(fssk_pkg::ACT_LOGOUT, 0, 0, fssk_pkg::ST_ENDED, 0, 0, 32'd1));
		add_row(mk_in(fssk_pkg::FUNC_START, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_LOGON, 5, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 1,
			mk_out(fssk_pkg::ACT_RESEND, 32'd1, 32'd1, fssk_pkg::ST_GAP, 1, 0, 32'd1));
		// bad frame not checked before logon
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_LOGON, 1, 0, 0,
			fssk_pkg::GF_ABSENT, 1, 0, 0, 0), 1, 1,
			mk_out(fssk_pkg::ACT_LOGON, 0, 0, fssk_pkg::ST_ACCEPTED, 1, 1, 32'd2));
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_LOGON, 2, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, 2, 0, 0,
			fssk_pkg::GF_ABSENT, 1, 1, 7, 0), 1, 0, none);
		// zero interval, then one tick already asks for a test request
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, 2, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 1, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_TICK, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		// interval 5: quiet, one heartbeat, then test request
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, 3, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 1, 5, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_TICK, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 7, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_TEST_REQ, 4, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, '1), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_REJECT, 5, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_RESEND, 6, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_OTHER, 7, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, '1, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		// too low: duplicate ignored, else logout
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, 3, 0, 1,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_HEARTBEAT, 3, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_START, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 7, 20, 0,
			fssk_pkg::GF_YES, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 20, 20, 0,
			fssk_pkg::GF_YES, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 5, 30, 1,
			fssk_pkg::GF_YES, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 5, 30, 0,
			fssk_pkg::GF_YES, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_START, fssk_pkg::MSG_LOGON, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 0, 10, 0,
			fssk_pkg::GF_NO, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 20, 40, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 20, 40, 0,
			fssk_pkg::GF_OTHER, 0, 0, 0, 0), 1, 0, none);
		// reset mode to the top, then wrap through zero
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_SEQ_RESET, 0, '1, 0,
			fssk_pkg::GF_NO, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_TEST_REQ, '1, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 64'h1), 1, 0, none);
		add_row(mk_in(fssk_pkg::FUNC_MSG, fssk_pkg::MSG_LOGOUT, 0, 0, 0,
			fssk_pkg::GF_ABSENT, 0, 0, 0, 0), 1, 0, none);

		phase_hb[0] = 16'hFFFF;
		phase_hb[1] = 16'd1;
		phase_hb[2] = 16'($urandom_range(2, 60));
		phase_hb[3] = 16'($urandom_range(1, 65535));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (row_item[i])
			repeat (row_reps[i])
				send_item(row_item[i], row_typed[i], row_reply[i]);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_interval(phase_hb[ph]);
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					it = gen_item();
					done++;
					send_item(it, 1'b0, none);
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					@(negedge clk);
					in_valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
		drain();
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
